FILE: rtl/m3i_pkg.sv
`timescale 1ns / 1ps

package m3i_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int ELEMENT_BITS = 32;
   localparam int THR_BITS     = 31;
   localparam int INT_BITS     = 64;                       // internal signed width
   localparam int PROD_BITS    = 2 * ELEMENT_BITS;         // element product
   localparam int DIFF_BITS    = PROD_BITS + 1;            // difference of two products
   localparam int COF_BITS     = DIFF_BITS - FRAC_BITS;    // rounded cofactor
   localparam int NUM_BITS     = COF_BITS + FRAC_BITS;     // |adj| * 2^F
   localparam int QUO_BITS     = ELEMENT_BITS;             // divider quotient bits
   localparam int FRONT_STAGES = 6;
   localparam int LANES        = 9;

   typedef struct packed {
      logic signed [ELEMENT_BITS-1:0] in_r0c0;
      logic signed [ELEMENT_BITS-1:0] in_r0c1;
      logic signed [ELEMENT_BITS-1:0] in_r0c2;
      logic signed [ELEMENT_BITS-1:0] in_r1c0;
      logic signed [ELEMENT_BITS-1:0] in_r1c1;
      logic signed [ELEMENT_BITS-1:0] in_r1c2;
      logic signed [ELEMENT_BITS-1:0] in_r2c0;
      logic signed [ELEMENT_BITS-1:0] in_r2c1;
      logic signed [ELEMENT_BITS-1:0] in_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [ELEMENT_BITS-1:0] out_r0c0;
      logic signed [ELEMENT_BITS-1:0] out_r0c1;
      logic signed [ELEMENT_BITS-1:0] out_r0c2;
      logic signed [ELEMENT_BITS-1:0] out_r1c0;
      logic signed [ELEMENT_BITS-1:0] out_r1c1;
      logic signed [ELEMENT_BITS-1:0] out_r1c2;
      logic signed [ELEMENT_BITS-1:0] out_r2c0;
      logic signed [ELEMENT_BITS-1:0] out_r2c1;
      logic signed [ELEMENT_BITS-1:0] out_r2c2;
      logic                           singular;
      logic signed [ELEMENT_BITS-1:0] determinant;
   } rsp_type;

   // front end result: adjugate, divisor magnitude and determinant status
   typedef struct packed {
      logic [LANES-1:0][COF_BITS-1:0] adj;
      logic [INT_BITS-1:0]            dmag;
      logic                           dneg;
      logic                           singular;
      logic [ELEMENT_BITS-1:0]        det;
   } front_type;

   // status that travels beside the divider lanes
   typedef struct packed {
      logic                    singular;
      logic [ELEMENT_BITS-1:0] det;
   } side_type;

   // last divider stage of one lane
   typedef struct packed {
      logic [QUO_BITS-1:0] quo;
      logic [INT_BITS-1:0] rem;
      logic                ovf;
      logic                neg;
      logic                byp;
   } lane_type;

   function automatic logic [ELEMENT_BITS-1:0] sat_cof(input logic [COF_BITS-1:0] v);
      logic [COF_BITS-ELEMENT_BITS:0] hi;
      hi = v[COF_BITS-1:ELEMENT_BITS-1];
      if ((&hi) || !(|hi)) return v[ELEMENT_BITS-1:0];
      return v[COF_BITS-1] ? {1'b1, {(ELEMENT_BITS-1){1'b0}}}
                           : {1'b0, {(ELEMENT_BITS-1){1'b1}}};
   endfunction

   function automatic logic [ELEMENT_BITS-1:0] sat_int(input logic [INT_BITS-1:0] v);
      logic [INT_BITS-ELEMENT_BITS:0] hi;
      hi = v[INT_BITS-1:ELEMENT_BITS-1];
      if ((&hi) || !(|hi)) return v[ELEMENT_BITS-1:0];
      return v[INT_BITS-1] ? {1'b1, {(ELEMENT_BITS-1){1'b0}}}
                           : {1'b0, {(ELEMENT_BITS-1){1'b1}}};
   endfunction

endpackage

FILE: rtl/m3i_front.sv
`timescale 1ns / 1ps

module m3i_front (
   input  logic                       clock,
   input  logic                       enable,
   input  m3i_pkg::req_type           req_data,
   input  logic [m3i_pkg::THR_BITS-1:0] threshold,
   output m3i_pkg::front_type         front
);
   import m3i_pkg::*;

   localparam int LowBits = COF_BITS - ELEMENT_BITS;          // low slice of cofactor
   localparam int SumBits = ELEMENT_BITS + COF_BITS + 2;
   localparam int RndBits = SumBits - FRAC_BITS;
   localparam logic [DIFF_BITS-1:0] HalfD = DIFF_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [SumBits-1:0]   HalfS = SumBits'(1) << (FRAC_BITS - 1);

   // operand pairs of each cofactor: a*b - c*d, row-major element numbers
   localparam int IdxA [LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int IdxB [LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int IdxC [LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int IdxD [LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   req_type                          in_ff;
   logic signed [ELEMENT_BITS-1:0]   m [LANES];
   logic signed [PROD_BITS-1:0]      pa_ff [LANES];
   logic signed [PROD_BITS-1:0]      pb_ff [LANES];
   logic signed [ELEMENT_BITS-1:0]   row1_ff [3];
   logic signed [ELEMENT_BITS-1:0]   row2_ff [3];
   logic [COF_BITS-1:0]              cof_in [LANES];
   logic [COF_BITS-1:0]              cof2_ff [LANES];
   logic [COF_BITS-1:0]              cof3_ff [LANES];
   logic [COF_BITS-1:0]              cof4_ff [LANES];
   logic signed [PROD_BITS-1:0]      ph_ff [3];
   logic signed [ELEMENT_BITS+LowBits:0] pl_ff [3];
   logic signed [SumBits-1:0]        sum_in;
   logic signed [SumBits-1:0]        sum_ff;
   front_type                        front_in;
   front_type                        front_ff;

   assign m[0] = in_ff.in_r0c0;
   assign m[1] = in_ff.in_r0c1;
   assign m[2] = in_ff.in_r0c2;
   assign m[3] = in_ff.in_r1c0;
   assign m[4] = in_ff.in_r1c1;
   assign m[5] = in_ff.in_r1c2;
   assign m[6] = in_ff.in_r2c0;
   assign m[7] = in_ff.in_r2c1;
   assign m[8] = in_ff.in_r2c2;

   always_comb begin
      logic [DIFF_BITS-1:0] diff;
      for (int k = 0; k < LANES; k++) begin
         diff = {pa_ff[k][PROD_BITS-1], pa_ff[k]} - {pb_ff[k][PROD_BITS-1], pb_ff[k]} + HalfD;
         cof_in[k] = diff[DIFF_BITS-1:FRAC_BITS];
      end
   end

   always_comb begin
      logic signed [SumBits-1:0] th;
      logic signed [SumBits-1:0] tl;
      sum_in = '0;
      for (int j = 0; j < 3; j++) begin
         th = SumBits'(ph_ff[j]);
         tl = SumBits'(pl_ff[j]);
         sum_in = sum_in + (th <<< LowBits) + tl;
      end
   end

   always_comb begin
      logic [SumBits-1:0]        rs;
      logic [RndBits-1:0]        rnd;
      logic [RndBits-INT_BITS:0] hi;
      logic [INT_BITS-1:0]       d64;
      logic [INT_BITS-1:0]       mag;
      rs  = sum_ff + HalfS;
      rnd = rs[SumBits-1:FRAC_BITS];
      hi  = rnd[RndBits-1:INT_BITS-1];
      if ((&hi) || !(|hi)) d64 = rnd[INT_BITS-1:0];
      else d64 = rnd[RndBits-1] ? {1'b1, {(INT_BITS-1){1'b0}}}
                                : {1'b0, {(INT_BITS-1){1'b1}}};
      mag = d64[INT_BITS-1] ? (~d64 + 1'b1) : d64;
      for (int k = 0; k < LANES; k++) front_in.adj[k] = cof4_ff[k];
      front_in.dmag     = mag;
      front_in.dneg     = d64[INT_BITS-1];
      front_in.singular = !(mag > INT_BITS'(threshold));
      front_in.det      = sat_int(d64);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         in_ff <= req_data;
         for (int k = 0; k < LANES; k++) begin
            pa_ff[k]   <= m[IdxA[k]] * m[IdxB[k]];
            pb_ff[k]   <= m[IdxC[k]] * m[IdxD[k]];
            cof2_ff[k] <= cof_in[k];
            cof3_ff[k] <= cof2_ff[k];
            cof4_ff[k] <= cof3_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            row1_ff[j] <= m[j];
            row2_ff[j] <= row1_ff[j];
            // row 0 times first adjugate column: adj[j][0]
            ph_ff[j] <= row2_ff[j] * $signed(cof2_ff[3*j][COF_BITS-1:LowBits]);
            pl_ff[j] <= row2_ff[j] * $signed({1'b0, cof2_ff[3*j][LowBits-1:0]});
         end
         sum_ff   <= sum_in;
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

FILE: rtl/m3i_div_lane.sv
`timescale 1ns / 1ps

module m3i_div_lane (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [m3i_pkg::COF_BITS-1:0] adj,
   input  logic                         det_neg,
   input  logic                         singular,
   input  logic [m3i_pkg::INT_BITS-1:0] dmag,
   input  logic [m3i_pkg::INT_BITS-1:0] divisor [m3i_pkg::QUO_BITS+1],
   output m3i_pkg::lane_type            lane
);
   import m3i_pkg::*;

   localparam int TopBits = NUM_BITS - QUO_BITS;

   logic [INT_BITS-1:0] rem_ff [QUO_BITS+1];
   logic [QUO_BITS-1:0] lo_ff  [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS+1];
   logic                ovf_ff [QUO_BITS+1];
   logic                neg_ff [QUO_BITS+1];
   logic                byp_ff [QUO_BITS+1];

   logic [COF_BITS-1:0] am;
   logic [NUM_BITS-1:0] num;
   logic [TopBits-1:0]  top;

   assign am  = adj[COF_BITS-1] ? (~adj + 1'b1) : adj;
   assign num = {am, {FRAC_BITS{1'b0}}};
   assign top = num[NUM_BITS-1:QUO_BITS];

   // setup: quotient would reach 2^QUO_BITS when num / 2^QUO_BITS >= divisor
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= INT_BITS'(top);
         lo_ff[0]  <= num[QUO_BITS-1:0];
         quo_ff[0] <= singular ? sat_cof(adj) : '0;
         ovf_ff[0] <= INT_BITS'(top) >= dmag;
         neg_ff[0] <= adj[COF_BITS-1] ^ det_neg;
         byp_ff[0] <= singular;
      end
   end

   for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
      logic [INT_BITS:0] r2;
      logic [INT_BITS:0] dif;
      logic              ge;

      assign r2  = {rem_ff[k-1], lo_ff[k-1][QUO_BITS-1]};
      assign dif = r2 - {1'b0, divisor[k-1]};
      assign ge  = r2 >= {1'b0, divisor[k-1]};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= ge ? dif[INT_BITS-1:0] : r2[INT_BITS-1:0];
            lo_ff[k]  <= lo_ff[k-1] << 1;
            quo_ff[k] <= byp_ff[k-1] ? quo_ff[k-1] : {quo_ff[k-1][QUO_BITS-2:0], ge};
            ovf_ff[k] <= ovf_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            byp_ff[k] <= byp_ff[k-1];
         end
      end
   end

   assign lane.quo = quo_ff[QUO_BITS];
   assign lane.rem = rem_ff[QUO_BITS];
   assign lane.ovf = ovf_ff[QUO_BITS];
   assign lane.neg = neg_ff[QUO_BITS];
   assign lane.byp = byp_ff[QUO_BITS];

endmodule

FILE: rtl/m3i_merge.sv
`timescale 1ns / 1ps

module m3i_merge (
   input  m3i_pkg::lane_type            lane [m3i_pkg::LANES],
   input  logic [m3i_pkg::INT_BITS-1:0] divisor,
   input  m3i_pkg::side_type            side,
   output m3i_pkg::rsp_type             rsp
);
   import m3i_pkg::*;

   logic [ELEMENT_BITS-1:0] elem [LANES];

   // round half away from zero on the remainder, then clamp to the element range
   always_comb begin
      logic                  rnd;
      logic [QUO_BITS:0]     qr;
      logic [ELEMENT_BITS:0] lim;
      logic [ELEMENT_BITS-1:0] magv;
      for (int k = 0; k < LANES; k++) begin
         rnd  = {lane[k].rem, 1'b0} >= {1'b0, divisor};
         qr   = {1'b0, lane[k].quo} + (QUO_BITS+1)'(rnd);
         lim  = {2'b00, {(ELEMENT_BITS-1){1'b1}}} + (ELEMENT_BITS+1)'(lane[k].neg);
         magv = (lane[k].ovf || ((ELEMENT_BITS+1)'(qr) > lim)) ? lim[ELEMENT_BITS-1:0]
                                                               : qr[ELEMENT_BITS-1:0];
         if (lane[k].byp) elem[k] = lane[k].quo;
         else elem[k] = lane[k].neg ? (~magv + 1'b1) : magv;
      end
   end

   assign rsp.out_r0c0    = elem[0];
   assign rsp.out_r0c1    = elem[1];
   assign rsp.out_r0c2    = elem[2];
   assign rsp.out_r1c0    = elem[3];
   assign rsp.out_r1c1    = elem[4];
   assign rsp.out_r1c2    = elem[5];
   assign rsp.out_r2c0    = elem[6];
   assign rsp.out_r2c1    = elem[7];
   assign rsp.out_r2c2    = elem[8];
   assign rsp.singular    = side.singular;
   assign rsp.determinant = side.det;

endmodule

FILE: rtl/matrix3x3_inverse_top.sv
`timescale 1ns / 1ps
// 3x3 Q16.16 matrix inverse via adjugate and determinant.
// Pipeline: 6 front stages for products, cofactors and determinant, then
//   33 stages of the radix-2 divider lanes and the output register.
// Throughput: one matrix per cycle; the whole pipeline holds only while a
//   result sits in the output register and rsp_stall is high.
// Reset (synchronous, active high) empties the pipeline and sets det_threshold to 1.

module matrix3x3_inverse_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  m3i_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output m3i_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [m3i_pkg::THR_BITS-1:0] csr_data
);
   import m3i_pkg::*;

   localparam int Depth = FRONT_STAGES + QUO_BITS + 1;   // stages before output reg

   logic                  adv;             // pipeline moves this cycle
   logic [Depth-1:0]      vld_ff;
   logic [Depth-1:0]      vld_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_in;
   logic [THR_BITS-1:0]   thr_ff;
   front_type             front;
   logic [INT_BITS-1:0]   div_ff  [QUO_BITS+1];   // divisor beside each divider stage
   side_type              side_ff [QUO_BITS+1];   // flag and determinant beside lanes
   lane_type              lane    [LANES];

   // output register drains or is empty: everything shifts one stage
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign vld_in    = {vld_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_BITS'(1);
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) thr_ff <= csr_data;
         if (adv) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= vld_ff[Depth-1];
         end
      end
   end

   m3i_front u_front (
      .clock     (clock),
      .enable    (adv),
      .req_data  (req_data),
      .threshold (thr_ff),
      .front     (front)
   );

   // divisor and status ride along the divider stages, shared by all lanes
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0]           <= front.dmag;
         side_ff[0].singular <= front.singular;
         side_ff[0].det      <= front.det;
         for (int k = 1; k <= QUO_BITS; k++) begin
            div_ff[k]  <= div_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      m3i_div_lane u_lane (
         .clock    (clock),
         .enable   (adv),
         .adj      (front.adj[k]),
         .det_neg  (front.dneg),
         .singular (front.singular),
         .dmag     (front.dmag),
         .divisor  (div_ff),
         .lane     (lane[k])
      );
   end

   m3i_merge u_merge (
      .lane    (lane),
      .divisor (div_ff[QUO_BITS]),
      .side    (side_ff[QUO_BITS]),
      .rsp     (rsp_in)
   );

   // output register: holds a result until its transfer
   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/m3i_checker.sv
`timescale 1ns / 1ps

module m3i_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input m3i_pkg::req_type             req_data,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input m3i_pkg::rsp_type             rsp_data,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [m3i_pkg::THR_BITS-1:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("input stalled while output free");

   a_zero_det_singular: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.singular |-> rsp_data.determinant != 0)
      else $error("zero determinant not flagged singular");

endmodule

bind matrix3x3_inverse_top m3i_checker u_m3i_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import m3i_pkg::*;

   // Holds the expected inverse results and the current threshold setting.
   class inverse_scoreboard;
      rsp_type                pending_inverses[$];
      logic [THR_BITS-1:0]    threshold = 1;
      int                     failures  = 0;

      // round half up from Q2F back to QF
      function automatic logic signed [99:0] cofactor(logic signed [99:0] a, b, c, d);
         logic signed [99:0] diff;
         diff = a * b - c * d;
         return (diff + 100'sd32768) >>> FRAC_BITS;
      endfunction

      function automatic logic [31:0] clamp32(logic signed [99:0] v);
         if (v > 100'sd2147483647) return 32'h7fff_ffff;
         if (v < -100'sd2147483648) return 32'h8000_0000;
         return v[31:0];
      endfunction

      // round(adj * 2^F / det), ties away from zero, then clamp
      function automatic logic [31:0] scale(logic signed [99:0] adj, logic signed [99:0] det,
                                            logic [127:0] dmag);
         logic [127:0] amag, num, quo, rem, lim;
         logic         neg;
         amag = adj < 0 ? 128'(-adj) : 128'(adj);
         num  = amag << FRAC_BITS;
         quo  = num / dmag;
         rem  = num % dmag;
         if (rem >= dmag - rem) quo = quo + 1;
         neg  = (adj < 0) != (det < 0);
         lim  = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         if (quo > lim) quo = lim;
         return neg ? 32'(-quo) : quo[31:0];
      endfunction

      function automatic rsp_type invert(req_type m);
         logic signed [99:0] e[9];
         logic signed [99:0] adj[9];
         logic signed [99:0] det;
         logic [127:0]       dmag;
         logic [31:0]        o[9];
         rsp_type            r;
         e[0] = m.in_r0c0; e[1] = m.in_r0c1; e[2] = m.in_r0c2;
         e[3] = m.in_r1c0; e[4] = m.in_r1c1; e[5] = m.in_r1c2;
         e[6] = m.in_r2c0; e[7] = m.in_r2c1; e[8] = m.in_r2c2;
         adj[0] = cofactor(e[4], e[8], e[5], e[7]);
         adj[1] = cofactor(e[2], e[7], e[1], e[8]);
         adj[2] = cofactor(e[1], e[5], e[2], e[4]);
         adj[3] = cofactor(e[5], e[6], e[3], e[8]);
         adj[4] = cofactor(e[0], e[8], e[2], e[6]);
         adj[5] = cofactor(e[2], e[3], e[0], e[5]);
         adj[6] = cofactor(e[3], e[7], e[4], e[6]);
         adj[7] = cofactor(e[1], e[6], e[0], e[7]);
         adj[8] = cofactor(e[0], e[4], e[1], e[3]);
         det = (e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6] + 100'sd32768) >>> FRAC_BITS;
         // internal determinant is a signed 64-bit value
         if (det > 100'sd9223372036854775807) det = 100'sd9223372036854775807;
         if (det < -100'sd9223372036854775808) det = -100'sd9223372036854775808;
         dmag = det < 0 ? 128'(-det) : 128'(det);
         r.singular = !(dmag > 128'(threshold));
         for (int i = 0; i < 9; i++)
            o[i] = r.singular ? clamp32(adj[i]) : scale(adj[i], det, dmag);
         r.out_r0c0 = o[0]; r.out_r0c1 = o[1]; r.out_r0c2 = o[2];
         r.out_r1c0 = o[3]; r.out_r1c1 = o[4]; r.out_r1c2 = o[5];
         r.out_r2c0 = o[6]; r.out_r2c1 = o[7]; r.out_r2c2 = o[8];
         r.determinant = clamp32(det);
         return r;
      endfunction

      function void note_matrix(req_type m);
         pending_inverses.push_back(invert(m));
      endfunction

      function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            failures++;
         end
      endfunction

      function void check_inverse(rsp_type act);
         rsp_type e;
         if (pending_inverses.size() == 0) begin
            $error("unexpected result transfer");
            failures++;
            return;
         end
         e = pending_inverses.pop_front();
         field("out_r0c0", e.out_r0c0, act.out_r0c0);
         field("out_r0c1", e.out_r0c1, act.out_r0c1);
         field("out_r0c2", e.out_r0c2, act.out_r0c2);
         field("out_r1c0", e.out_r1c0, act.out_r1c0);
         field("out_r1c1", e.out_r1c1, act.out_r1c1);
         field("out_r1c2", e.out_r1c2, act.out_r1c2);
         field("out_r2c0", e.out_r2c0, act.out_r2c0);
         field("out_r2c1", e.out_r2c1, act.out_r2c1);
         field("out_r2c2", e.out_r2c2, act.out_r2c2);
         field("singular", 32'(e.singular), 32'(act.singular));
         field("determinant", e.determinant, act.determinant);
      endfunction
   endclass

   localparam int STALL_LIMIT = 3000;   // cycles with no transfer before giving up
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off

   logic                clock     = 0;
   logic                reset     = 1;
   logic                req_valid = 0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   rsp_type             rsp_data;
   logic                csr_valid = 0;
   logic                csr_ready;
   logic [THR_BITS-1:0] csr_data  = '0;

   inverse_scoreboard   sb = new();
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   logic                hold_req      = 0;
   bit                  hold_seen     = 0;
   int                  hold_left     = 0;
   int                  quiet_cycles  = 0;

   matrix3x3_inverse_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Monitor: every accepted matrix and result transfer goes to the scoreboard;
   // the watchdog counts cycles in which nothing moves on any channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_matrix(req_data);
         if (rsp_valid && !rsp_stall) sb.check_inverse(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Receiver: random stall, plus one long hold-off on request.
   always @(posedge clock) begin
      if (hold_req && !hold_seen) begin
         hold_seen = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // One matrix transfer; valid stays high across back-to-back items.
   task automatic send_matrix(req_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= m;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_inverses.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   // Threshold write, only with the pipeline empty.
   task automatic write_threshold(logic [THR_BITS-1:0] thr);
      drain();
      csr_valid <= 1;
      csr_data  <= thr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.threshold = thr;
   endtask

   function automatic logic [31:0] pick_element();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) return 32'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      if (sel < 75) return 32'($signed($urandom_range(0, 512)) - 256);
      if (sel < 92) return $urandom;
      case ($urandom_range(4))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0001_0000;
         3: return 32'hffff_0000;
         default: return 32'h0;
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      m = {pick_element(), pick_element(), pick_element(), pick_element(), pick_element(),
           pick_element(), pick_element(), pick_element(), pick_element()};
      // now and then make row 2 a copy of row 0 to hit exact singularity
      if ($urandom_range(19) == 0) begin
         m.in_r2c0 = m.in_r0c0;
         m.in_r2c1 = m.in_r0c1;
         m.in_r2c2 = m.in_r0c2;
      end
      return m;
   endfunction

   function automatic req_type diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      req_type m;
      m = '0;
      m.in_r0c0 = a;
      m.in_r1c1 = b;
      m.in_r2c2 = c;
      return m;
   endfunction

   task automatic random_phase(int count, int send_pct, int recv_pct, bit pressure);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (pressure && i == count / 3) hold_req <= 1;   // block fills behind the hold
         if (pressure && i == 2 * count / 3) begin
            // sender pause until everything is back
            req_valid <= 0;
            @(posedge clock);
            while (sb.pending_inverses.size() != 0) @(posedge clock);
         end
         send_matrix(random_matrix());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part, default threshold.
      send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));  // identity
      send_matrix('0);                                                   // zero determinant
      send_matrix(diag(32'h0002_0000, 32'h0000_8000, 32'hfffc_0000));
      send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));   // overflowing det
      send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_matrix({9{32'h7fff_ffff}});
      send_matrix({9{32'h8000_0000}});
      send_matrix({9{32'hffff_ffff}});
      send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));   // det rounds to 0
      send_matrix(diag(32'h0000_0001, 32'h0001_0000, 32'h0000_0001));   // tiny det
      send_matrix(diag(32'h0000_0002, 32'h0001_0000, 32'h0000_0001));   // det near threshold
      send_matrix({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000});
      send_matrix({32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000,
                   32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0000_0000});
      send_matrix({32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333,
                   32'hcccc_cccc, 32'h00ff_00ff, 32'hff00_ff00, 32'h1234_5678});

      // Threshold zero: only an exact zero is singular.
      write_threshold('0);
      send_matrix('0);
      send_matrix(diag(32'h0000_0001, 32'h0001_0000, 32'h0000_0001));
      send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
      send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));

      // Threshold maximum: nearly everything is singular.
      write_threshold({THR_BITS{1'b1}});
      send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_matrix({9{32'h8000_0000}});

      // Random part: three idle profiles, threshold changed between them.
      write_threshold(THR_BITS'(1));
      random_phase(500, 24, 66, 0);
      write_threshold(THR_BITS'($urandom_range(0, 1 << 18)));
      random_phase(500, 66, 24, 1);
      write_threshold(31'h0001_0000);
      random_phase(500, 0, 0, 0);

      req_valid <= 0;
      while (sb.pending_inverses.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
      if (sb.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
